// ===== sv/wcmd_pkg.sv =====
// Shared types and constants for the waveform column min/max decimator.
// No dependencies; imported by every module of the block.
package wcmd_pkg;

    // Fixed widths of the config registers and result fields
    localparam int STEP_W    = 16;
    localparam int COUNT_W   = 13;
    localparam int COLUMN_W  = 12;
    localparam int ROW_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_STEP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    // Register reset values
    localparam logic [STEP_W-1:0]  PIXEL_STEP_RST   = 16'd4096;
    localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 13'd1024;

    // Column tracker status handed to the envelope and output stage
    typedef struct packed {
        logic                bar;     // integer column changed on this sample
        logic [COLUMN_W-1:0] column;  // column just left
    } wcmd_pos_stat_t;

endpackage

// ===== sv/waveform_column_minmax_decimator.sv =====
// Min/max envelope decimator, one bar per finished column. It takes one input beat
// per cycle while no bar is stalled: an accepted sample waits in the input register
// until the result register can take a bar; its bar, if any, is registered onto m_*.
// The single position add/compare/wrap path and the min/max fold set that rate.
// Reset (aresetn, sync, active low): position 0, min/max empty, registers to defaults.
// Depends on wcmd_pkg, wcmd_position, wcmd_envelope.
module waveform_column_minmax_decimator #(
    parameter int MAX_COLUMNS = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_we,
    input  logic [wcmd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [wcmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample,
    // bar output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [wcmd_pkg::COLUMN_W-1:0]    m_column,
    output logic [wcmd_pkg::ROW_W-1:0]       m_row_low,
    output logic [wcmd_pkg::ROW_W-1:0]       m_row_high
);
    import wcmd_pkg::*;

    // Config registers
    logic [STEP_W-1:0]  pixel_step_reg;
    logic [COUNT_W-1:0] column_count_reg;

    // Input register
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // Result register
    logic                out_valid_reg;
    logic [COLUMN_W-1:0] out_column_reg;
    logic [ROW_W-1:0]    out_row_low_reg, out_row_high_reg;

    logic           s_fire, proc_fire, out_take;
    wcmd_pos_stat_t pos_stat;
    logic [ROW_W-1:0] row_low, row_high;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_step_reg   <= PIXEL_STEP_RST;
            column_count_reg <= COLUMN_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PIXEL_STEP:   pixel_step_reg   <= cfg_wdata[STEP_W-1:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The held sample is folded in once the result register can take its bar.
    // A stalled bar only blocks the sample behind it; an empty input register
    // still accepts a beat.
    assign out_take  = out_valid_reg && m_ready;
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_sample_reg <= s_sample;
        end
    end

    wcmd_position #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_position (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (proc_fire),
        .pixel_step   (pixel_step_reg),
        .column_count (column_count_reg),
        .stat         (pos_stat)
    );

    wcmd_envelope #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_envelope (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (proc_fire),
        .bar      (pos_stat.bar),
        .sample   (in_sample_reg),
        .row_low  (row_low),
        .row_high (row_high)
    );

    // Result register: loads a bar when a processed sample leaves its column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && pos_stat.bar) begin
            out_valid_reg <= 1'b1;
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && pos_stat.bar) begin
            out_column_reg   <= pos_stat.column;
            out_row_low_reg  <= row_low;
            out_row_high_reg <= row_high;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_column   = out_column_reg;
    assign m_row_low  = out_row_low_reg;
    assign m_row_high = out_row_high_reg;

endmodule

// ===== sv/wcmd_position.sv =====
// Fractional pixel position accumulator with wrap at the column count.
// Depends on wcmd_pkg.
module wcmd_position #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [wcmd_pkg::STEP_W-1:0]    pixel_step,
    input  logic [wcmd_pkg::COUNT_W-1:0]   column_count,
    output wcmd_pkg::wcmd_pos_stat_t       stat
);
    import wcmd_pkg::*;

    localparam int COL_BITS = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS = COL_BITS + 1;
    localparam int CMP_BITS = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
    localparam int POS_W    = COL_BITS + FRAC_W;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CMP_BITS-1:0] count_ext, count_eff;
    logic [POS_W:0]      sum;
    logic [CNT_BITS-1:0] sum_int;
    logic [CMP_BITS-1:0] sum_int_ext, wrapped;
    logic [COL_BITS-1:0] old_col, new_col;

    // Out-of-range count (zero or above the max) runs as the max
    always_comb begin
        count_ext = CMP_BITS'(column_count);
        if (column_count == '0 || count_ext > CMP_BITS'(MAX_COLUMNS)) begin
            count_eff = CMP_BITS'(MAX_COLUMNS);
        end else begin
            count_eff = count_ext;
        end
    end

    // One add, one compare, at most one subtract per sample
    always_comb begin
        sum         = {1'b0, pos_reg} + (POS_W+1)'(pixel_step);
        sum_int     = sum[POS_W:FRAC_W];
        sum_int_ext = CMP_BITS'(sum_int);
        wrapped     = sum_int_ext - count_eff;
        if (sum_int_ext >= count_eff) begin
            new_col = wrapped[COL_BITS-1:0];
        end else begin
            new_col = sum_int[COL_BITS-1:0];
        end
        old_col     = pos_reg[POS_W-1:FRAC_W];
        pos_next    = {new_col, sum[FRAC_W-1:0]};
        stat.bar    = (new_col != old_col);
        stat.column = COLUMN_W'(old_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== sv/wcmd_envelope.sv =====
// Running min/max tracker and row mapping for one display column.
// Depends on wcmd_pkg.
module wcmd_envelope #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          bar,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic [wcmd_pkg::ROW_W-1:0]    row_low,
    output logic [wcmd_pkg::ROW_W-1:0]    row_high
);
    import wcmd_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] EMPTY_MIN = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] EMPTY_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int T_W = SAMPLE_BITS + 8;

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next, max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] s, min_fold, max_fold;

    // floor(128 + 127*s) with s as a fraction of full scale; never negative
    function automatic logic [ROW_W-1:0] row_of(input logic [SAMPLE_BITS-1:0] v);
        logic [T_W-1:0] ext;
        logic [T_W-1:0] t;
        ext = {{8{v[SAMPLE_BITS-1]}}, v};
        t   = (ext << 7) - ext + (T_W'(1) << (SAMPLE_BITS + 6));
        return t[SAMPLE_BITS+6:SAMPLE_BITS-1];
    endfunction

    always_comb begin
        s        = sample;
        min_fold = (s < min_reg) ? s : min_reg;
        max_fold = (s > max_reg) ? s : max_reg;
        row_low  = row_of(min_fold);
        row_high = row_of(max_fold);
        if (bar) begin
            min_next = EMPTY_MIN;
            max_next = EMPTY_MAX;
        end else begin
            min_next = min_fold;
            max_next = max_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= EMPTY_MIN;
            max_reg <= EMPTY_MAX;
        end else if (advance) begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// ===== sv/wcmd_checker.sv =====
// Port-level checks on the decimator's bar output, attached by bind.
// Depends on wcmd_pkg and waveform_column_minmax_decimator.
module wcmd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [wcmd_pkg::COLUMN_W-1:0]   m_column,
    input logic [wcmd_pkg::ROW_W-1:0]      m_row_low,
    input logic [wcmd_pkg::ROW_W-1:0]      m_row_high
);
    import wcmd_pkg::*;

    // no bar survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("bar valid right after reset");

    // min row never above max row within one bar
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_row_low <= m_row_high))
        else $error("row_low above row_high");

    // rows stay inside 1..254
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_row_low != '0) && (m_row_high != '1))
        else $error("row out of range");

    // stalled bar holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column)
            && $stable(m_row_low) && $stable(m_row_high))
        else $error("stalled bar changed");

endmodule

bind waveform_column_minmax_decimator wcmd_checker u_wcmd_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking bench for waveform_column_minmax_decimator: random and directed samples,
// bars predicted in-bench and compared beat by beat. Depends on wcmd_pkg and the RTL.
module tb_top;
    import wcmd_pkg::*;

    localparam int MAX_COLS   = 4096;
    localparam int SMP_W      = 16;
    localparam int PHASE_LEN  = 88;    // random beats per phase
    localparam int NUM_PHASES = 12;
    localparam int SETTLE_CYC = 4;     // settle margin after the block goes idle

    // One finished column as seen on the m_* side
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row_low;
        logic [ROW_W-1:0]    row_high;
    } bar_t;

    // Clock, reset and DUT ports; the bench-driven ones are known from time zero
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic signed [SMP_W-1:0] s_sample  = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic [COLUMN_W-1:0]     m_column;
    logic [ROW_W-1:0]        m_row_low;
    logic [ROW_W-1:0]        m_row_high;

    // Stimulus and scoreboard storage
    logic signed [SMP_W-1:0] samples_todo[$];
    bar_t                    bars_due[$];
    int                      sender_idle_pct = 0;
    int                      recv_stall_pct  = 0;
    int                      mismatches      = 0;
    int                      bars_seen       = 0;

    // Shadow of the block: Q16.16 position, running envelope and registers
    logic [31:0]             pos_acc   = '0;
    logic signed [SMP_W-1:0] env_min   = 16'sh7FFF;
    logic signed [SMP_W-1:0] env_max   = 16'sh8000;
    logic [STEP_W-1:0]       step_reg  = PIXEL_STEP_RST;
    logic [COUNT_W-1:0]      count_reg = COLUMN_COUNT_RST;

    waveform_column_minmax_decimator #(
        .MAX_COLUMNS (MAX_COLS),
        .SAMPLE_BITS (SMP_W)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_column   (m_column),
        .m_row_low  (m_row_low),
        .m_row_high (m_row_high)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor(128 + 127 * level / 2^15); never negative for a 16-bit level
    function automatic logic [ROW_W-1:0] row_of_level(input logic signed [SMP_W-1:0] lvl);
        logic signed [31:0] t;
        t = 32'sd127 * lvl + (32'sd128 <<< (SMP_W - 1));
        return t[SMP_W+6:SMP_W-1];
    endfunction

    // Fold one accepted sample into the shadow state; queue a bar if the column moved.
    // The sample is folded before the bar is cut, so it belongs to the bar it completes.
    task automatic fold_sample(input logic signed [SMP_W-1:0] smp);
        logic [13:0] wrap_cols;
        logic [15:0] old_int;
        bar_t        bar;
        // zero or oversized count falls back to the full width
        wrap_cols = (count_reg == 0 || count_reg > MAX_COLS) ? 14'(MAX_COLS) : 14'(count_reg);
        if (smp < env_min) env_min = smp;
        if (smp > env_max) env_max = smp;
        old_int = pos_acc[31:16];
        pos_acc = pos_acc + 32'(step_reg);
        // one subtraction only: after a lowered count the position walks back
        if (pos_acc[31:16] >= 16'(wrap_cols))
            pos_acc = pos_acc - {2'b0, wrap_cols, 16'd0};
        if (pos_acc[31:16] != old_int) begin
            bar.column   = old_int[COLUMN_W-1:0];
            bar.row_low  = row_of_level(env_min);
            bar.row_high = row_of_level(env_max);
            bars_due.push_back(bar);
            env_min = 16'sh7FFF;
            env_max = 16'sh8000;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("bar %0d: %s got %0d want %0d", bars_seen, what, got, want);
        mismatches++;
    endtask

    // Driver: next beat from the pending queue, gaps per the current idle rate.
    // The shadow model advances on the edge where the beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                fold_sample(s_sample);
            if (!s_valid || s_ready) begin
                if (samples_todo.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= samples_todo.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, each taken bar checked against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bars_due.size() == 0) begin
                    report_mismatch("unexpected bar, column", m_column, -1);
                end else begin
                    bar_t want;
                    want = bars_due.pop_front();
                    if (m_column !== want.column)
                        report_mismatch("column", m_column, want.column);
                    if (m_row_low !== want.row_low)
                        report_mismatch("row_low", m_row_low, want.row_low);
                    if (m_row_high !== want.row_high)
                        report_mismatch("row_high", m_row_high, want.row_high);
                end
                bars_seen++;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Block idle: nothing pending, nothing in flight, nothing owed; then latency margin.
    // Sampled on the falling edge so the driver's and monitor's updates have settled.
    task automatic wait_idle();
        while (samples_todo.size() != 0 || s_valid || bars_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == CFG_PIXEL_STEP)
            step_reg = val;
        else if (idx == CFG_COLUMN_COUNT)
            count_reg = val[COUNT_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input int step, input int count);
        write_reg(CFG_PIXEL_STEP, CFG_DATA_W'(step));
        write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(count));
    endtask

    // Mix of full-scale extremes, small signals and raw random words
    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int phase_step;
        int phase_count;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // reset defaults, no write
        samples_todo.push_back(16'sh7FFF);
        samples_todo.push_back(16'sh8000);
        samples_todo.push_back(16'sh0000);
        samples_todo.push_back(16'shFFFF);
        wait_idle();
        // step just under one pixel, count 0 -> full width: a bar per beat, rows at extremes
        set_registers(65535, 0);
        samples_todo.push_back(16'sh8000);
        samples_todo.push_back(16'sh7FFF);
        samples_todo.push_back(16'sh0000);
        samples_todo.push_back(16'shFFFF);
        samples_todo.push_back(16'sh0001);
        samples_todo.push_back(16'sh5555);
        samples_todo.push_back(16'shAAAA);
        samples_todo.push_back(16'sh7FFF);
        wait_idle();
        // zero step with an oversized count: no bars at all
        set_registers(0, 8191);
        samples_todo.push_back(16'sh8000);
        samples_todo.push_back(16'sh7FFF);
        samples_todo.push_back(16'sh1234);
        samples_todo.push_back(16'shEDCB);
        wait_idle();
        // half-pixel step on two columns, entered above the count: position walks back, a bar per beat
        set_registers(32768, 2);
        samples_todo.push_back(16'sh8000);
        samples_todo.push_back(16'sh7FFF);
        samples_todo.push_back(16'sh0100);
        samples_todo.push_back(16'shFF00);
        samples_todo.push_back(16'sh4000);
        samples_todo.push_back(16'shC000);
        wait_idle();
        // single column: position wraps in place
        set_registers(65535, 1);
        samples_todo.push_back(16'sh7FFF);
        samples_todo.push_back(16'sh8000);
        samples_todo.push_back(16'sh0000);
        wait_idle();

        // --- random phases ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin phase_step = PIXEL_STEP_RST; phase_count = COLUMN_COUNT_RST; end
                1:       begin phase_step = 65535; phase_count = MAX_COLS; end
                2:       begin phase_step = $urandom_range(40000, 65535); phase_count = 0; end
                // count dropped under a high position: walk-back over several beats
                3:       begin phase_step = $urandom_range(20000, 65535); phase_count = 3; end
                4:       begin phase_step = 0; phase_count = $urandom_range(1, 4096); end
                5:       begin phase_step = 1; phase_count = 1; end
                6:       begin phase_step = 65535; phase_count = 8191; end
                7:       begin phase_step = 65535; phase_count = 1; end
                default: begin
                    phase_step  = $urandom_range(8192, 65535);
                    phase_count = ph[0] ? $urandom_range(1, 48) : $urandom_range(49, 4096);
                end
            endcase
            set_registers(phase_step, phase_count);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int k = 0; k < PHASE_LEN / 2; k++)
                samples_todo.push_back(pick_sample());
            // sender holds off until every owed bar is out
            wait_idle();
            for (int k = PHASE_LEN / 2; k < PHASE_LEN; k++)
                samples_todo.push_back(pick_sample());
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (bars_due.size() != 0)
            report_mismatch("bars never seen", 0, bars_due.size());
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
